@@ rtl/poi_pkg.sv @@
// Shared types, constants and the arctangent table for the planar odometry integrator.
`timescale 1ns / 1ps
`default_nettype none
package poi_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int YAW_BITS_DEF     = 24;
  localparam int ATAN_LEN         = 24;

  // CORDIC datapath width: Q1.30 values plus sign and growth headroom.
  localparam int CW = 34;

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = CW'(652032874);
  localparam logic signed [22:0]   INV_TWO_PI_Q24  = 23'(2670177);

  typedef struct packed {
    logic signed [15:0] lin_vel_x;
    logic signed [15:0] lin_vel_y;
    logic signed [15:0] yaw_rate;
    logic        [19:0] elapsed;
  } poi_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } poi_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORD1,
    S_MUL,
    S_ACC,
    S_START2,
    S_CORD2,
    S_DONE
  } poi_state_t;

  // Arctangent of 2^-i as a 32 bit fraction of a turn.
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/poi_cordic.sv @@
// Iterative rotation-mode CORDIC giving cosine and sine of a turn fraction in Q1.30.
`timescale 1ns / 1ps
`default_nettype none
module poi_cordic #(
  parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [31:0]                   angle,
  output logic                               done,
  output logic signed [poi_pkg::CW-1:0]      cos_q,
  output logic signed [poi_pkg::CW-1:0]      sin_q
);
  import poi_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [4:0]           i_r, i_nxt;
  logic                 flip_r, flip_nxt;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [CW-1:0] dx, dy, at;
  logic [31:0]          folded;
  logic                 flip_in;

  // Fold the angle into a quarter turn either side of zero.
  assign flip_in = angle[31] ^ angle[30];
  assign folded  = flip_in ? (angle - 32'h80000000) : angle;

  // One micro-rotation per cycle through a shared shifter and adder set.
  always_comb begin
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = CW'(atan_turn(i_r));
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    i_nxt    = i_r;
    flip_nxt = flip_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      i_nxt    = 5'd0;
      flip_nxt = flip_in;
      x_nxt    = CORDIC_GAIN_Q30;
      y_nxt    = '0;
      z_nxt    = CW'(signed'(folded));
    end else if (busy_r) begin
      if (!z_r[CW-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    i_r    <= i_nxt;
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign done  = done_r;
  assign cos_q = flip_r ? -x_r : x_r;
  assign sin_q = flip_r ? -y_r : y_r;

  // A new rotation is only started when the unit is free.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("CORDIC started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("CORDIC done while still iterating");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("CORDIC done held longer than one cycle");

endmodule
`default_nettype wire

@@ rtl/planar_odometry_integrator.sv @@
// Top level of the planar odometry integrator: sequencer, shared multiplier and accumulators.
// A request passes through a first CORDIC run, eight multiplier passes (each a multiply and an
// accumulate state), a second CORDIC start and run, and the done state before its result is
// valid. Requests are taken one at a time; the next request is accepted once the sequencer is
// back in idle, even while the previous result still waits in the output register. A result
// that still waits holds the sequencer in its done state.
// Reset (synchronous, active low) clears position, heading and all handshake state.
`timescale 1ns / 1ps
`default_nettype none
module planar_odometry_integrator #(
  parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF,
  parameter int YAW_BITS     = poi_pkg::YAW_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire poi_pkg::poi_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output poi_pkg::poi_out_t     out_data
);
  import poi_pkg::*;

  localparam int SH = 52 - YAW_BITS;

  poi_state_t state_r, state_nxt;
  logic [2:0] op_r;

  poi_in_t              req_r;
  logic signed [31:0]   x_acc_r, y_acc_r;
  logic [YAW_BITS-1:0]  yaw_r;
  logic signed [CW-1:0] c_r, s_r;
  logic signed [58:0]   p_r, acc_r;
  logic signed [32:0]   rx_r, ry_r;
  logic signed [35:0]   wd_r;
  logic                 out_valid_r;
  logic signed [15:0]   quat_z_r, quat_w_r;
  poi_out_t             out_shadow_r;

  logic                 cord_start, cord_done;
  logic [31:0]          cord_angle, full_angle;
  logic signed [CW-1:0] cord_cos, cord_sin;
  logic signed [35:0]   mul_a;
  logic signed [22:0]   mul_b;
  logic signed [58:0]   p_nxt;
  logic                 load_out;

  logic signed [59:0]   t_rx, t_ry, t_pos, t_yaw;
  logic signed [33:0]   sum_pos;
  logic signed [31:0]   pos_sat;
  logic signed [34:0]   t_qz, t_qw;
  logic signed [15:0]   qz, qw;

  assign full_angle = 32'(yaw_r) << (32 - YAW_BITS);

  poi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .angle (cord_angle),
    .done  (cord_done),
    .cos_q (cord_cos),
    .sin_q (cord_sin)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CORD1;
      S_CORD1:  if (cord_done) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_ACC;
      S_ACC:    state_nxt = (op_r == 3'd7) ? S_START2 : S_MUL;
      S_START2: state_nxt = S_CORD2;
      S_CORD2:  if (cord_done) state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    cord_start = 1'b0;
    cord_angle = full_angle;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cord_start = in_valid;
      end
      S_START2: begin
        cord_start = 1'b1;
        cord_angle = full_angle >> 1;
      end
      S_DONE:   load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (op_r)
      3'd0:    begin mul_a = 36'(c_r);  mul_b = 23'(req_r.lin_vel_x); end
      3'd1:    begin mul_a = 36'(s_r);  mul_b = 23'(req_r.lin_vel_y); end
      3'd2:    begin mul_a = 36'(s_r);  mul_b = 23'(req_r.lin_vel_x); end
      3'd3:    begin mul_a = 36'(c_r);  mul_b = 23'(req_r.lin_vel_y); end
      3'd4:    begin mul_a = 36'(rx_r); mul_b = {3'b000, req_r.elapsed}; end
      3'd5:    begin mul_a = 36'(ry_r); mul_b = {3'b000, req_r.elapsed}; end
      3'd6:    begin mul_a = 36'(req_r.yaw_rate); mul_b = {3'b000, req_r.elapsed}; end
      3'd7:    begin mul_a = wd_r;      mul_b = INV_TWO_PI_Q24; end
      default: begin mul_a = '0;        mul_b = '0; end
    endcase
  end
  assign p_nxt = mul_a * mul_b;

  // Rounded shifts and saturation on the registered product and on the CORDIC outputs.
  always_comb begin
    t_rx  = 60'(acc_r) - 60'(p_r) + 60'sd8192;
    t_ry  = 60'(acc_r) + 60'(p_r) + 60'sd8192;
    t_pos = 60'(p_r) + (60'sd1 <<< 27);
    t_yaw = 60'(p_r) + (60'sd1 <<< (SH - 1));
    sum_pos = (op_r == 3'd4) ? 34'(x_acc_r) : 34'(y_acc_r);
    sum_pos = sum_pos + 34'(signed'(t_pos[59:28]));
    if (sum_pos > 34'sh07FFFFFFF)       pos_sat = 32'sh7FFFFFFF;
    else if (sum_pos < -34'sh080000000) pos_sat = 32'sh80000000;
    else                                pos_sat = sum_pos[31:0];
    t_qz = 35'(cord_sin) + 35'sd16384;
    t_qw = 35'(cord_cos) + 35'sd16384;
    if ((t_qz >>> 15) > 35'sd32767) qz = 16'sh7FFF;
    else                            qz = t_qz[30:15];
    if ((t_qw >>> 15) > 35'sd32767)       qw = 16'sh7FFF;
    else if ((t_qw >>> 15) < -35'sd32768) qw = 16'sh8000;
    else                                  qw = t_qw[30:15];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= 3'd0;
      out_valid_r <= 1'b0;
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      yaw_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) op_r <= 3'd0;
      else if (state_r == S_ACC) op_r <= op_r + 3'd1;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == S_ACC) begin
        if (op_r == 3'd4) x_acc_r <= pos_sat;
        if (op_r == 3'd5) y_acc_r <= pos_sat;
        if (op_r == 3'd7) yaw_r <= yaw_r + t_yaw[SH +: YAW_BITS];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) req_r <= in_data;
    if (state_r == S_CORD1 && cord_done) begin
      c_r <= cord_cos;
      s_r <= cord_sin;
    end
    if (state_r == S_MUL) p_r <= p_nxt;
    if (state_r == S_ACC) begin
      unique case (op_r)
        3'd0, 3'd2: acc_r <= p_r;
        3'd1:       rx_r  <= t_rx[46:14];
        3'd3:       ry_r  <= t_ry[46:14];
        3'd6:       wd_r  <= p_r[35:0];
        default: ;
      endcase
    end
    if (state_r == S_CORD2 && cord_done) begin
      quat_z_r <= qz;
      quat_w_r <= qw;
    end
  end

  // Output register, loaded when the result is published.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_shadow_r.pos_x   <= x_acc_r;
      out_shadow_r.pos_y   <= y_acc_r;
      out_shadow_r.heading <= yaw_r[YAW_BITS-1 -: 16];
      out_shadow_r.quat_z  <= quat_z_r;
      out_shadow_r.quat_w  <= quat_w_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_shadow_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("request accepted while sequencer busy");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CORD1))
    else $error("accepted request did not start CORDIC");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result published outside done state");
  a_cordic_done_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> (state_r == S_CORD1 || state_r == S_CORD2))
    else $error("CORDIC finished outside a CORDIC state");

endmodule
`default_nettype wire
